>>> hdl/rvnp_pkg.sv
package rvnp_pkg;

  // Fixed field widths
  localparam int LEN_W      = 24;
  localparam int TS_W       = 32;
  localparam int SSRC_W     = 32;
  localparam int SEQ_W      = 16;
  localparam int TOTAL_W    = 16;
  localparam int SLOT_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_SEGMENT_DEFAULT = 1460;
  localparam int HDR_ROOM            = 16;
  localparam int RTP_HDR_LEN         = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODEC_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SSRC       = 1'd1;

  // Byte constants of the packet layout
  localparam logic [7:0] PREFIX_MAGIC   = 8'h24;
  localparam logic [7:0] PREFIX_CHANNEL = 8'h00;
  localparam logic [7:0] RTP_V2_BYTE    = 8'h80;
  localparam logic [6:0] PT_H264        = 7'd96;
  localparam logic [6:0] PT_H265        = 7'd97;
  localparam logic [4:0] FU_A_TYPE      = 5'h1C;
  localparam logic [7:0] H265_FU_BYTE0  = 8'd98;
  localparam logic [7:0] H265_FU_BYTE1  = 8'd1;

  // Result slots within one burst: 0..15 header, 16..18 FU bytes, 19 payload
  localparam logic [SLOT_W-1:0] SLOT_FIRST    = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR_LAST = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_FU_LONG  = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_FU_SHORT = 5'd17;
  localparam logic [SLOT_W-1:0] SLOT_PAYLOAD  = 5'd19;
  localparam logic [SLOT_W-1:0] PREFIX_SLOTS  = 5'd4;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic             frame_start;
    logic [LEN_W-1:0] frame_length;
    logic [TS_W-1:0]  timestamp;
  } frame_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_begin;
    logic       packet_end;
    logic       tcp_prefix_only;
    logic       key_packet;
    logic       run_end;
  } packet_t;

  // Everything one input byte produces
  typedef struct packed {
    logic               hdr;
    logic               has_fu;
    logic               fu_long;
    logic [TOTAL_W-1:0] total;
    logic [7:0]         pt_byte;
    logic [SEQ_W-1:0]   seq;
    logic [TS_W-1:0]    ts;
    logic [7:0]         fu0;
    logic [7:0]         fu1;
    logic [7:0]         fu2;
    logic [7:0]         payload;
    logic               pay_end;
    logic               key;
  } burst_t;

endpackage

>>> hdl/rvnp_parse.sv
module rvnp_parse #(
  parameter int MAX_SEGMENT = rvnp_pkg::MAX_SEGMENT_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  rvnp_pkg::frame_t item,
  input  logic            codec_mode,
  output rvnp_pkg::burst_t desc,
  output logic            desc_valid
);

  localparam int LEN_W      = rvnp_pkg::LEN_W;
  localparam int FILL_W     = $clog2(MAX_SEGMENT);
  localparam int SINGLE_MAX = MAX_SEGMENT - rvnp_pkg::HDR_ROOM;
  localparam int FLEN_264   = SINGLE_MAX - 2;
  localparam int FLEN_265   = SINGLE_MAX - 3;

  logic [rvnp_pkg::SEQ_W-1:0] sequence_counter, sequence_counter_next;
  logic [LEN_W-1:0]           byte_position, byte_position_next;
  logic [LEN_W-1:0]           bytes_remaining, bytes_remaining_next;
  logic [FILL_W-1:0]          fragment_fill, fragment_fill_next;
  logic [7:0]                 nal_header_byte, nal_header_byte_next;
  logic                       fragmenting, fragmenting_next;
  logic                       first_fragment_pending, first_fragment_pending_next;
  logic                       key_pending, key_pending_next;
  logic [rvnp_pkg::TS_W-1:0]  held_timestamp, held_timestamp_next;

  logic [LEN_W-1:0]             rem0, pos0, flen;
  logic [FILL_W-1:0]            fill0, fill_inc;
  logic                         frag0, ffp0, key0, frag_last, pay_end, frag_end;
  logic [rvnp_pkg::SEQ_W-1:0]   seq_inc;
  logic [rvnp_pkg::TOTAL_W-1:0] plen;
  logic [7:0]                   b;

  function automatic logic is_key(input logic [7:0] h, input logic h265);
    logic k;
    k = 1'b0;
    if (!h265) begin
      case (h[4:0]) inside
        5'd5, 5'd7, 5'd8: k = 1'b1;
        default:          k = 1'b0;
      endcase
    end else begin
      case (h[6:1]) inside
        6'd2, 6'd19, 6'd32, 6'd33, 6'd34: k = 1'b1;
        default:                          k = 1'b0;
      endcase
    end
    return k;
  endfunction

  always_comb begin
    b     = item.frame_byte;
    rem0  = item.frame_start ? item.frame_length : bytes_remaining;
    pos0  = item.frame_start ? '0 : byte_position;
    fill0 = item.frame_start ? '0 : fragment_fill;
    frag0 = item.frame_start ? 1'b0 : fragmenting;
    ffp0  = item.frame_start ? 1'b0 : first_fragment_pending;
    key0  = item.frame_start ? 1'b0 : key_pending;

    flen      = codec_mode ? LEN_W'(FLEN_265) : LEN_W'(FLEN_264);
    frag_last = (rem0 <= flen);
    plen      = frag_last ? rem0[rvnp_pkg::TOTAL_W-1:0] : flen[rvnp_pkg::TOTAL_W-1:0];
    fill_inc  = fill0 + FILL_W'(1);
    pay_end   = (rem0 == LEN_W'(1));
    frag_end  = (LEN_W'(fill_inc) >= flen) || pay_end;
    seq_inc   = sequence_counter + 16'd1;

    sequence_counter_next       = sequence_counter;
    byte_position_next          = pos0;
    bytes_remaining_next        = rem0;
    fragment_fill_next          = fill0;
    nal_header_byte_next        = nal_header_byte;
    fragmenting_next            = frag0;
    first_fragment_pending_next = ffp0;
    key_pending_next            = key0;
    held_timestamp_next         = item.frame_start ? item.timestamp : held_timestamp;

    desc         = '0;
    desc.seq     = seq_inc;
    desc.ts      = held_timestamp_next;
    desc.payload = b;
    desc.pay_end = pay_end;
    desc.key     = key0;
    desc_valid   = 1'b0;

    if (rem0 != '0) begin
      bytes_remaining_next = rem0 - LEN_W'(1);
      byte_position_next   = pos0 + LEN_W'(1);
      if (pos0 == LEN_W'(4)) begin
        nal_header_byte_next = b;
        key_pending_next     = is_key(b, codec_mode);
        desc.key             = key_pending_next;
        if (rem0 > LEN_W'(SINGLE_MAX)) begin
          fragmenting_next            = 1'b1;
          first_fragment_pending_next = 1'b1;
          fragment_fill_next          = '0;
        end else begin
          fragmenting_next      = 1'b0;
          sequence_counter_next = seq_inc;
          desc_valid            = 1'b1;
          desc.hdr              = 1'b1;
          desc.total            = rem0[rvnp_pkg::TOTAL_W-1:0] +
                                  rvnp_pkg::TOTAL_W'(rvnp_pkg::RTP_HDR_LEN);
          desc.pt_byte          = codec_mode ? {~b[6], rvnp_pkg::PT_H265}
                                             : {1'b0, rvnp_pkg::PT_H264};
        end
      end else if (pos0 > LEN_W'(4)) begin
        if (!frag0) begin
          desc_valid = 1'b1;
        end else if (pos0 >= (codec_mode ? LEN_W'(6) : LEN_W'(5))) begin
          desc_valid   = 1'b1;
          desc.pay_end = frag_end;
          if (fill0 == '0) begin
            sequence_counter_next       = seq_inc;
            first_fragment_pending_next = 1'b0;
            desc.hdr     = 1'b1;
            desc.has_fu  = 1'b1;
            desc.fu_long = codec_mode;
            desc.total   = plen + (codec_mode ? rvnp_pkg::TOTAL_W'(15)
                                              : rvnp_pkg::TOTAL_W'(14));
            desc.pt_byte = {frag_last, codec_mode ? rvnp_pkg::PT_H265 : rvnp_pkg::PT_H264};
            if (codec_mode) begin
              desc.fu0 = rvnp_pkg::H265_FU_BYTE0;
              desc.fu1 = rvnp_pkg::H265_FU_BYTE1;
              desc.fu2 = {ffp0, frag_last, nal_header_byte[6:1]};
            end else begin
              desc.fu1 = {1'b0, nal_header_byte[6:5], rvnp_pkg::FU_A_TYPE};
              desc.fu2 = {ffp0, frag_last, 1'b0, nal_header_byte[4:0]};
            end
          end
          fragment_fill_next = frag_end ? '0 : fill_inc;
          if (frag_end) begin
            key_pending_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter       <= '0;
      byte_position          <= '0;
      bytes_remaining        <= '0;
      fragment_fill          <= '0;
      nal_header_byte        <= '0;
      fragmenting            <= 1'b0;
      first_fragment_pending <= 1'b0;
      key_pending            <= 1'b0;
      held_timestamp         <= '0;
    end else if (take) begin
      sequence_counter       <= sequence_counter_next;
      byte_position          <= byte_position_next;
      bytes_remaining        <= bytes_remaining_next;
      fragment_fill          <= fragment_fill_next;
      nal_header_byte        <= nal_header_byte_next;
      fragmenting            <= fragmenting_next;
      first_fragment_pending <= first_fragment_pending_next;
      key_pending            <= key_pending_next;
      held_timestamp         <= held_timestamp_next;
    end
  end

endmodule

>>> hdl/rvnp_emit.sv
module rvnp_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  rvnp_pkg::burst_t                  desc,
  input  logic [rvnp_pkg::SSRC_W-1:0]       ssrc,
  output logic                              can_take,
  output logic                              packet_valid,
  input  logic                              packet_stall,
  output rvnp_pkg::packet_t                 packet
);

  logic                         burst_valid;
  rvnp_pkg::burst_t             burst;
  logic [rvnp_pkg::SLOT_W-1:0]  slot, slot_next;
  logic                         out_move, last_move;
  rvnp_pkg::packet_t            elem;

  assign out_move  = burst_valid && (!packet_valid || !packet_stall);
  assign last_move = out_move && (slot == rvnp_pkg::SLOT_PAYLOAD);
  assign can_take  = !burst_valid || last_move;

  // Skip the FU slots that this burst does not use
  always_comb begin
    if (slot == rvnp_pkg::SLOT_HDR_LAST) begin
      if (!burst.has_fu) begin
        slot_next = rvnp_pkg::SLOT_PAYLOAD;
      end else if (burst.fu_long) begin
        slot_next = rvnp_pkg::SLOT_FU_LONG;
      end else begin
        slot_next = rvnp_pkg::SLOT_FU_SHORT;
      end
    end else begin
      slot_next = slot + rvnp_pkg::SLOT_W'(1);
    end
  end

  always_comb begin
    elem                 = '0;
    elem.packet_begin    = (slot == rvnp_pkg::SLOT_FIRST);
    elem.tcp_prefix_only = (slot < rvnp_pkg::PREFIX_SLOTS);
    elem.key_packet      = burst.key;
    elem.run_end         = (slot == rvnp_pkg::SLOT_PAYLOAD);
    elem.packet_end      = (slot == rvnp_pkg::SLOT_PAYLOAD) && burst.pay_end;
    case (slot)
      5'd0:    elem.packet_byte = rvnp_pkg::PREFIX_MAGIC;
      5'd1:    elem.packet_byte = rvnp_pkg::PREFIX_CHANNEL;
      5'd2:    elem.packet_byte = burst.total[15:8];
      5'd3:    elem.packet_byte = burst.total[7:0];
      5'd4:    elem.packet_byte = rvnp_pkg::RTP_V2_BYTE;
      5'd5:    elem.packet_byte = burst.pt_byte;
      5'd6:    elem.packet_byte = burst.seq[15:8];
      5'd7:    elem.packet_byte = burst.seq[7:0];
      5'd8:    elem.packet_byte = burst.ts[31:24];
      5'd9:    elem.packet_byte = burst.ts[23:16];
      5'd10:   elem.packet_byte = burst.ts[15:8];
      5'd11:   elem.packet_byte = burst.ts[7:0];
      5'd12:   elem.packet_byte = ssrc[31:24];
      5'd13:   elem.packet_byte = ssrc[23:16];
      5'd14:   elem.packet_byte = ssrc[15:8];
      5'd15:   elem.packet_byte = ssrc[7:0];
      5'd16:   elem.packet_byte = burst.fu0;
      5'd17:   elem.packet_byte = burst.fu1;
      5'd18:   elem.packet_byte = burst.fu2;
      default: elem.packet_byte = burst.payload;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
    end else if (load) begin
      burst_valid <= 1'b1;
    end else if (last_move) begin
      burst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= desc;
      slot  <= desc.hdr ? rvnp_pkg::SLOT_FIRST : rvnp_pkg::SLOT_PAYLOAD;
    end else if (out_move) begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
    end else if (out_move) begin
      packet_valid <= 1'b1;
    end else if (!packet_stall) begin
      packet_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      packet <= elem;
    end
  end

endmodule

>>> hdl/rtp_video_nal_packetizer.sv
// RTP video NAL packetizer, H.264 / H.265, RTP over TCP interleaved framing.
// Frame channel: one frame byte per request (frame_valid / frame_stall). The
// request with frame_start set also carries frame_length and timestamp. The
// first four bytes of a frame (start code) are dropped; the fifth is the NAL
// header, which picks key / not key and single packet versus FU fragments.
// Packet channel: one packet byte per request (packet_valid / packet_stall),
// with begin/end, prefix, key and run_end flags. Each frame byte yields up
// to 20 packet bytes: 4 prefix bytes, 12 RTP header bytes, up to 3 FU bytes
// and the payload byte itself.
// The first result of a byte is registered in the burst register and then
// in the output register.
// Throughput: one frame byte per cycle for payload-only bytes while the
// receiver does not stall; a byte that opens a packet holds the frame
// channel while its burst drains through the single output register.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// codec_mode or the SSRC. Write only while the block is idle.
// Reset (rst, synchronous): clears all frame state, sequence number and
// config registers; no burst or result is pending afterwards.
// Receiver stall: the output register holds its byte, the burst stops, and
// frame_stall rises until the burst's last byte has moved out.
module rtp_video_nal_packetizer #(
  parameter int MAX_SEGMENT = rvnp_pkg::MAX_SEGMENT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              frame_valid,
  output logic                              frame_stall,
  input  rvnp_pkg::frame_t                  frame,
  output logic                              packet_valid,
  input  logic                              packet_stall,
  output rvnp_pkg::packet_t                 packet,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rvnp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvnp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                          codec_mode;
  logic [rvnp_pkg::SSRC_W-1:0]   stream_source_id;
  logic                          can_take, take, desc_valid;
  rvnp_pkg::burst_t              desc;

  assign cfg_ready   = 1'b1;
  assign frame_stall = !can_take;
  assign take        = frame_valid && can_take;

  // Config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode       <= 1'b0;
      stream_source_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rvnp_pkg::REG_CODEC_MODE: codec_mode       <= cfg_data[0];
        rvnp_pkg::REG_SSRC:       stream_source_id <= cfg_data[rvnp_pkg::SSRC_W-1:0];
        default:                  codec_mode       <= codec_mode;
      endcase
    end
  end

  // Per-byte frame state and burst description
  rvnp_parse #(
    .MAX_SEGMENT(MAX_SEGMENT)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (frame),
    .codec_mode (codec_mode),
    .desc       (desc),
    .desc_valid (desc_valid)
  );

  // Burst serializer and output register
  rvnp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (take && desc_valid),
    .desc         (desc),
    .ssrc         (stream_source_id),
    .can_take     (can_take),
    .packet_valid (packet_valid),
    .packet_stall (packet_stall),
    .packet       (packet)
  );

endmodule

>>> hdl/rvnp_checker.sv
module rvnp_checker (
  input logic              clk,
  input logic              rst,
  input logic              packet_valid,
  input logic              packet_stall,
  input rvnp_pkg::packet_t packet
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    packet_valid && packet_stall |=> packet_valid && $stable(packet))
    else $error("stalled packet byte changed");

  a_begin_prefix: assert property (@(posedge clk) disable iff (rst)
    packet_valid && packet.packet_begin |-> packet.tcp_prefix_only && !packet.run_end)
    else $error("packet begin outside the prefix");

  a_end_run: assert property (@(posedge clk) disable iff (rst)
    packet_valid && packet.packet_end |-> packet.run_end && !packet.tcp_prefix_only)
    else $error("packet end not on a payload byte");

  a_header_burst: assert property (@(posedge clk) disable iff (rst)
    packet_valid && packet.packet_begin && !packet_stall |=>
      packet_valid && packet.tcp_prefix_only && !packet.packet_begin)
    else $error("header burst broken after packet begin");

endmodule

bind rtp_video_nal_packetizer rvnp_checker u_rvnp_checker (
  .clk          (clk),
  .rst          (rst),
  .packet_valid (packet_valid),
  .packet_stall (packet_stall),
  .packet       (packet)
);

>>> verif/rtp_video_nal_packetizer_checker.sv
module rtp_video_nal_packetizer_checker #(
  parameter int MAX_SEGMENT = rvnp_pkg::MAX_SEGMENT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_valid,
  input  logic                            frame_stall,
  input  rvnp_pkg::frame_t                frame,
  input  logic                            packet_valid,
  input  logic                            packet_stall,
  input  rvnp_pkg::packet_t               packet,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rvnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rvnp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              bytes_awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import rvnp_pkg::*;

  localparam int NAL_LIMIT      = MAX_SEGMENT - HDR_ROOM;
  localparam int START_CODE_LEN = 4;
  localparam int FU_LEN_H264    = 2;
  localparam int FU_LEN_H265    = 3;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [4:0] H264_IDR = 5'd5;
  localparam logic [4:0] H264_SPS = 5'd7;
  localparam logic [4:0] H264_PPS = 5'd8;

  localparam logic [5:0] H265_TSA_N      = 6'd2;
  localparam logic [5:0] H265_IDR_W_RADL = 6'd19;
  localparam logic [5:0] H265_VPS        = 6'd32;
  localparam logic [5:0] H265_SPS        = 6'd33;
  localparam logic [5:0] H265_PPS        = 6'd34;

  logic        use_h265;
  logic [31:0] ssrc;
  logic [15:0] seq_num;
  logic [23:0] byte_pos;
  logic [23:0] bytes_left;
  logic [10:0] frag_fill;
  logic [7:0]  nal_hdr;
  logic        in_fragments;
  logic        first_frag;
  logic        key_nal;
  logic [31:0] frame_ts;

  packet_t     pending_packet_bytes[$];
  packet_t     run[$];
  int          reported;

  function automatic logic key_header(logic [7:0] h, logic h265);
    if (!h265) begin
      return h[4:0] == H264_IDR || h[4:0] == H264_SPS || h[4:0] == H264_PPS;
    end
    return h[6:1] == H265_TSA_N || h[6:1] == H265_IDR_W_RADL || h[6:1] == H265_VPS ||
           h[6:1] == H265_SPS || h[6:1] == H265_PPS;
  endfunction

  task automatic put_byte(logic [7:0] b, logic first, logic last, logic prefix);
    packet_t p;
    p.packet_byte     = b;
    p.packet_begin    = first;
    p.packet_end      = last;
    p.tcp_prefix_only = prefix;
    p.key_packet      = key_nal;
    p.run_end         = 1'b0;
    run.push_back(p);
  endtask

  // Interleaved prefix and RTP header; sequence advances before use.
  task automatic put_header(int plen, logic marker);
    logic [31:0] total;
    total   = plen + RTP_HDR_LEN;
    seq_num = seq_num + 16'd1;
    put_byte(PREFIX_MAGIC, 1'b1, 1'b0, 1'b1);
    put_byte(PREFIX_CHANNEL, 1'b0, 1'b0, 1'b1);
    put_byte(total[15:8], 1'b0, 1'b0, 1'b1);
    put_byte(total[7:0], 1'b0, 1'b0, 1'b1);
    put_byte(RTP_V2_BYTE, 1'b0, 1'b0, 1'b0);
    put_byte({marker, use_h265 ? PT_H265 : PT_H264}, 1'b0, 1'b0, 1'b0);
    put_byte(seq_num[15:8], 1'b0, 1'b0, 1'b0);
    put_byte(seq_num[7:0], 1'b0, 1'b0, 1'b0);
    put_byte(frame_ts[31:24], 1'b0, 1'b0, 1'b0);
    put_byte(frame_ts[23:16], 1'b0, 1'b0, 1'b0);
    put_byte(frame_ts[15:8], 1'b0, 1'b0, 1'b0);
    put_byte(frame_ts[7:0], 1'b0, 1'b0, 1'b0);
    put_byte(ssrc[31:24], 1'b0, 1'b0, 1'b0);
    put_byte(ssrc[23:16], 1'b0, 1'b0, 1'b0);
    put_byte(ssrc[15:8], 1'b0, 1'b0, 1'b0);
    put_byte(ssrc[7:0], 1'b0, 1'b0, 1'b0);
  endtask

  // Work out the packet bytes that one frame byte produces.
  task automatic packetize_byte(frame_t f);
    logic [23:0] at;
    logic [23:0] left;
    logic [7:0]  b;
    int          nal_len;
    int          fu_len;
    int          flen;
    int          plen;
    logic        last;
    logic        done;
    b = f.frame_byte;
    if (f.frame_start) begin
      byte_pos     = '0;
      bytes_left   = f.frame_length;
      frame_ts     = f.timestamp;
      in_fragments = 1'b0;
      first_frag   = 1'b0;
      key_nal      = 1'b0;
      frag_fill    = '0;
    end
    if (bytes_left == 0) return;
    at         = byte_pos;
    bytes_left = bytes_left - 24'd1;
    byte_pos   = byte_pos + 24'd1;
    left       = bytes_left;
    if (at < START_CODE_LEN) return;
    nal_len = left;
    nal_len = nal_len + 1;
    if (at == START_CODE_LEN) begin
      nal_hdr = b;
      key_nal = key_header(b, use_h265);
      if (nal_len > NAL_LIMIT) begin
        in_fragments = 1'b1;
        first_frag   = 1'b1;
        frag_fill    = '0;
      end else begin
        in_fragments = 1'b0;
        put_header(nal_len, use_h265 && b[6:1] < H265_VPS);
        put_byte(b, 1'b0, left == 0, 1'b0);
      end
    end else if (!in_fragments) begin
      put_byte(b, 1'b0, left == 0, 1'b0);
    end else begin
      fu_len = use_h265 ? FU_LEN_H265 : FU_LEN_H264;
      flen   = NAL_LIMIT - fu_len;
      // H.265 payload skips both header bytes
      if (at < START_CODE_LEN + fu_len - 1) return;
      if (frag_fill == 0) begin
        plen = (nal_len < flen) ? nal_len : flen;
        last = nal_len <= flen;
        put_header(plen + fu_len, last);
        if (use_h265) begin
          put_byte(H265_FU_BYTE0, 1'b0, 1'b0, 1'b0);
          put_byte(H265_FU_BYTE1, 1'b0, 1'b0, 1'b0);
          put_byte({first_frag, last, nal_hdr[6:1]}, 1'b0, 1'b0, 1'b0);
        end else begin
          put_byte({1'b0, nal_hdr[6:5], FU_A_TYPE}, 1'b0, 1'b0, 1'b0);
          put_byte({first_frag, last, 1'b0, nal_hdr[4:0]}, 1'b0, 1'b0, 1'b0);
        end
        first_frag = 1'b0;
      end
      frag_fill = frag_fill + 11'd1;
      done = (frag_fill >= flen) || (left == 0);
      put_byte(b, 1'b0, done, 1'b0);
      if (done) begin
        frag_fill = '0;
        key_nal   = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    packet_t want;
    packet_t got;
    if (rst) begin
      use_h265     = 1'b0;
      ssrc         = '0;
      seq_num      = '0;
      byte_pos     = '0;
      bytes_left   = '0;
      frag_fill    = '0;
      nal_hdr      = '0;
      in_fragments = 1'b0;
      first_frag   = 1'b0;
      key_nal      = 1'b0;
      frame_ts     = '0;
      pending_packet_bytes.delete();
      mismatches   = 0;
      reported     = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CODEC_MODE) use_h265 = cfg_data[0];
        else if (cfg_index == REG_SSRC) ssrc = cfg_data;
      end
      if (frame_valid && !frame_stall) begin
        run.delete();
        packetize_byte(frame);
        if (run.size() > 0) begin
          want = run[run.size()-1];
          want.run_end = 1'b1;
          run[run.size()-1] = want;
        end
        foreach (run[i]) pending_packet_bytes.push_back(run[i]);
      end
      if (packet_valid && !packet_stall) begin
        got = packet;
        if (pending_packet_bytes.size() == 0) begin
          mismatches++;
          if (reported < REPORT_LIMIT)
            $display("%0t: unexpected packet byte %02h b%0b e%0b t%0b k%0b r%0b", $time,
                     got.packet_byte, got.packet_begin, got.packet_end,
                     got.tcp_prefix_only, got.key_packet, got.run_end);
          reported++;
        end else begin
          want = pending_packet_bytes.pop_front();
          if (got.packet_byte !== want.packet_byte || got.packet_begin !== want.packet_begin ||
              got.packet_end !== want.packet_end ||
              got.tcp_prefix_only !== want.tcp_prefix_only ||
              got.key_packet !== want.key_packet || got.run_end !== want.run_end) begin
            mismatches++;
            if (reported < REPORT_LIMIT)
              $display({"%0t: packet byte mismatch, expected %02h b%0b e%0b t%0b k%0b r%0b,",
                        " got %02h b%0b e%0b t%0b k%0b r%0b"}, $time,
                       want.packet_byte, want.packet_begin, want.packet_end,
                       want.tcp_prefix_only, want.key_packet, want.run_end,
                       got.packet_byte, got.packet_begin, got.packet_end,
                       got.tcp_prefix_only, got.key_packet, got.run_end);
            reported++;
          end
        end
      end
    end
    bytes_awaited = pending_packet_bytes.size();
  end

endmodule

>>> verif/rtp_video_nal_packetizer_test.sv
module rtp_video_nal_packetizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rvnp_pkg::*;

  // Cycles to let the block finish a byte that produces nothing; the first
  // result of a request goes through the burst and then the output register.
  localparam int SETTLE_CYCLES  = 8;
  // Long receiver hold-off, well past one full burst per frame byte
  localparam int HOLD_CYCLES    = 400;
  // Frame bytes per random phase, and how often to pause and reconfigure
  localparam int PHASE_ITEMS    = 140;
  localparam int RECONFIG_EVERY = 50;

  logic                  clk;
  logic                  rst;
  logic                  frame_valid;
  logic                  frame_stall;
  frame_t                frame;
  logic                  packet_valid;
  logic                  packet_stall;
  packet_t               packet;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int bytes_awaited;

  // Idle rates in percent, set per phase by the stimulus process
  int send_idle_pct;
  int recv_idle_pct;
  // Hold-off handshake between stimulus and receiver: requested vs served
  int hold_requests;
  int hold_served;
  int hold_left;
  int phase_items;

  rtp_video_nal_packetizer dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .packet_valid (packet_valid),
    .packet_stall (packet_stall),
    .packet       (packet),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rtp_video_nal_packetizer_checker packet_check (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .frame         (frame),
    .packet_valid  (packet_valid),
    .packet_stall  (packet_stall),
    .packet        (packet),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .bytes_awaited (bytes_awaited)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall at random at the current rate, or hold off for a long
  // stretch whenever the stimulus asks for one.
  initial begin
    packet_stall = 1'b0;
    hold_served  = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        packet_stall <= 1'b1;
      end else begin
        packet_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("FAIL rtp_video_nal_packetizer");
    $finish;
  end

  // Mix plain headers, key headers of both codecs and random bytes.
  function automatic logic [7:0] pick_nal_header();
    case ($urandom_range(11))
      0:       return 8'h65;  // H.264 IDR slice
      1:       return 8'h67;  // H.264 SPS
      2:       return 8'h68;  // H.264 PPS
      3:       return 8'h41;  // H.264 non-IDR slice
      4:       return 8'h40;  // H.265 VPS
      5:       return 8'h42;  // H.265 SPS
      6:       return 8'h44;  // H.265 PPS
      7:       return 8'h26;  // H.265 IDR_W_RADL
      8:       return 8'h04;  // H.265 TSA_N
      9:       return 8'h02;  // H.265 trailing picture
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one frame byte; hold it until the block takes it. Returns at the
  // falling edge after acceptance with valid still high, so a following
  // request goes out back to back.
  task automatic push_byte(logic [7:0] b, logic start, logic [23:0] len, logic [31:0] ts);
    frame_t f;
    f.frame_byte   = b;
    f.frame_start  = start;
    f.frame_length = len;
    f.timestamp    = ts;
    while ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    do @(posedge clk); while (frame_stall);
    @(negedge clk);
  endtask

  // Send the first count bytes of a frame: start code (mostly well formed),
  // NAL header at offset four, random payload. Fields that only matter with
  // frame_start are randomized on the other bytes.
  task automatic send_frame(logic [23:0] len, int count, logic [7:0] hdr, logic [31:0] ts);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      if (i == 4) b = hdr;
      else if (i < 4 && $urandom_range(3) != 0) b = (i == 3) ? 8'h01 : 8'h00;
      else b = 8'($urandom_range(255));
      if (i == 0) push_byte(b, 1'b1, len, ts);
      else push_byte(b, 1'b0, 24'($urandom), $urandom);
    end
    phase_items += count;
  endtask

  // Write both registers back to back; upper data bits of the codec write
  // are noise that the block must drop.
  task automatic configure(logic h265, logic [31:0] ssrc);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CODEC_MODE;
    cfg_data  <= ($urandom & 32'hFFFF_FFFE) | {31'd0, h265};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_SSRC;
    cfg_data  <= ssrc;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted byte, then let the block settle.
  task automatic drain();
    frame_valid <= 1'b0;
    while (bytes_awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_frame();
    int          pick;
    int          count;
    logic [23:0] len;
    pick = $urandom_range(99);
    if (pick < 5) begin
      // loose bytes; dropped unless an abandoned frame is still open
      repeat ($urandom_range(1, 3))
        push_byte(8'($urandom_range(255)), 1'b0, 24'($urandom), $urandom);
    end else if (pick < 10) begin
      // too short to reach a NAL header
      len = 24'($urandom_range(4));
      send_frame(len, (len == 0) ? 1 : len, pick_nal_header(), $urandom);
    end else if (pick < 16) begin
      // any length at all, cut off early by the next frame start
      len = 24'($urandom);
      send_frame(len, $urandom_range(1, 12), pick_nal_header(), $urandom);
    end else begin
      len = 24'($urandom_range(5, 28));
      count = ($urandom_range(19) == 0) ? $urandom_range(1, len) : len;
      send_frame(len, count, pick_nal_header(), $urandom);
    end
  endtask

  initial begin
    int next_reconfig;
    rst           = 1'b1;
    frame_valid   = 1'b0;
    frame         = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    phase_items   = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part, H.264 first with an all-ones SSRC
    configure(1'b0, 32'hFFFF_FFFF);
    push_byte(8'hA5, 1'b0, 24'd9, 32'd0);         // no frame open: drop
    send_frame(24'd0, 1, 8'h00, 32'h1234_5678);    // zero length frame
    send_frame(24'd4, 4, 8'h00, 32'h0000_0001);    // start code only
    send_frame(24'd5, 5, 8'h65, 32'hFFFF_FFFF);    // header-only key NAL
    // largest length: enters FU-A, then abandoned by the next frame start
    send_frame(24'hFF_FFFF, 6, 8'hFF, 32'd0);
    // switch codec mid-frame while fragmenting: payload restarts one byte
    // later and the FU layout changes to H.265
    send_frame(24'd3000, 5, 8'h7C, $urandom);
    drain();
    configure(1'b1, 32'd0);
    push_byte(8'h00, 1'b0, 24'($urandom), $urandom);
    push_byte(8'hFF, 1'b0, 24'($urandom), $urandom);
    send_frame(24'd5, 5, 8'h26, $urandom);        // H.265 IDR alone, marker set

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      configure(phase == 1, $urandom);
      phase_items   = 0;
      next_reconfig = RECONFIG_EVERY;
      while (phase_items < PHASE_ITEMS) begin
        random_frame();
        // back up the block: receiver holds off while requests keep coming
        if (phase == 2 && hold_requests == 0 && phase_items > 30) hold_requests++;
        if (phase_items >= next_reconfig) begin
          drain();
          configure(1'($urandom_range(1)), $urandom);
          next_reconfig += RECONFIG_EVERY;
        end
      end
    end

    drain();
    if (mismatches == 0 && bytes_awaited == 0) begin
      $display("PASS rtp_video_nal_packetizer");
    end else begin
      $display("FAIL rtp_video_nal_packetizer");
    end
    $finish;
  end

endmodule
